// ----- sv/rpn_pkg.sv -----
// ---------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the reverse Polish stack evaluator.
// ---------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_STEPS   = 32;
  localparam int DSTEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADCHAR  = 3'd1;
  localparam logic [2:0] ST_FEW      = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_NOTONE   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Command broadcast to every stack cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t   cmd;
    logic [31:0] data;
  } cell_ctl_t;

endpackage

// ----- sv/rpn_if.sv -----
// ---------------------------------------------------------------------------
// rpn_in_if / rpn_out_if
// Valid/ready channels for characters and results.
// ---------------------------------------------------------------------------
interface rpn_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expr;
  modport source (output valid, char_code, end_of_expr, input ready);
  modport sink (input valid, char_code, end_of_expr, output ready);
endinterface

interface rpn_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

// ----- sv/rpn_cell.sv -----
// ---------------------------------------------------------------------------
// rpn_cell
// One stack word; shifts toward the top or bottom neighbor on push/pop.
// ---------------------------------------------------------------------------
module rpn_cell (
  input  logic              clk,
  input  rpn_pkg::cell_ctl_t ctl,
  input  logic [31:0]       from_up,
  input  logic [31:0]       from_down,
  input  logic              is_top,
  output logic [31:0]       word
);

  // Push: top cell loads new data, others take the word above.
  // Pop: the top cell loads the result, others take the word below.
  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      rpn_pkg::CMD_PUSH: word <= is_top ? ctl.data : from_up;
      rpn_pkg::CMD_POP:  word <= is_top ? ctl.data : from_down;
      default:           word <= word;
    endcase
  end

endmodule

// ----- sv/rpn_div.sv -----
// ---------------------------------------------------------------------------
// rpn_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
module rpn_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] lhs,
  input  logic [31:0] rhs,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] rem, q, dvs;
  logic        neg, busy;
  logic [rpn_pkg::DSTEP_W-1:0] steps;
  logic [32:0] trial;

  assign trial = {rem[30:0], q[31]} - {1'b0, dvs};
  assign quot  = neg ? 32'd0 - q : q;

  // Shift one dividend bit into the remainder per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= rpn_pkg::DSTEP_W'(rpn_pkg::DIV_STEPS);
        rem   <= '0;
        q     <= lhs[31] ? 32'd0 - lhs : lhs;
        dvs   <= rhs[31] ? 32'd0 - rhs : rhs;
        neg   <= lhs[31] ^ rhs[31];
      end else if (busy) begin
        if (trial[32]) begin
          rem <= {rem[30:0], q[31]};
          q   <= {q[30:0], 1'b0};
        end else begin
          rem <= trial[31:0];
          q   <= {q[30:0], 1'b1};
        end
        steps <= steps - 1'b1;
        if (steps == rpn_pkg::DSTEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/rpn_stack_evaluator.sv -----
// ---------------------------------------------------------------------------
// rpn_stack_evaluator
// Streaming reverse Polish integer evaluator on a chain of stack cells.
// ---------------------------------------------------------------------------
// Usage: characters enter on in_ch (char_code, end_of_expr), one transfer
// each. Digits push, + - * / combine the two top words, whitespace is
// skipped. On the character marked end_of_expr one result leaves on
// out_ch: value (0 unless status is ok) and status.
// Each character is accepted in S_IDLE and updates the stack in S_EXEC;
// no new character is taken before that, and a division also waits in
// S_DIV for the 32-step divider. The result is registered with the last
// character's stack update and holds until taken; input is accepted only
// once the output register is free, so a stalled receiver stalls input.
// Reset (rst, synchronous) empties the stack and clears the error; stack
// words themselves are not cleared. Stack depth is rpn_pkg::STACK_DEPTH.
// ---------------------------------------------------------------------------
module rpn_stack_evaluator (
  input logic   clk,
  input logic   rst,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);

  localparam int D = rpn_pkg::STACK_DEPTH;
  localparam int W = rpn_pkg::CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_t;

  state_t          state;
  logic [7:0]      ch;
  logic            last;
  logic [W-1:0]    count;
  logic [2:0]      err;
  logic [31:0]     words [D];
  rpn_pkg::cell_ctl_t ctl;
  logic            div_start, div_done;
  logic [31:0]     quot, lhs, rhs, res;
  logic            is_digit, is_op, is_space, finish;
  logic [2:0]      err_next;
  logic [W-1:0]    count_next;

  // Words of the chain: index 0 is the top of the stack
  assign rhs = words[0];
  assign lhs = words[1];

  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      rpn_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .from_up  (gi == 0 ? 32'd0 : words[(gi == 0) ? 0 : gi - 1]),
        .from_down(gi == D - 1 ? 32'd0 : words[(gi == D - 1) ? gi : gi + 1]),
        .is_top   (gi == 0),
        .word     (words[gi])
      );
    end
  endgenerate

  rpn_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .lhs  (lhs),
    .rhs  (rhs),
    .done (div_done),
    .quot (quot)
  );

  // Classify the held character
  assign is_digit = ch >= rpn_pkg::CH_ZERO && ch <= rpn_pkg::CH_NINE;
  assign is_op    = ch == rpn_pkg::CH_PLUS || ch == rpn_pkg::CH_MINUS ||
                    ch == rpn_pkg::CH_STAR || ch == rpn_pkg::CH_SLASH;
  assign is_space = ch == rpn_pkg::CH_SPACE ||
                    (ch >= rpn_pkg::CH_TAB && ch <= rpn_pkg::CH_CR);

  // Decide the stack command and error for this character
  always_comb begin
    ctl.cmd    = rpn_pkg::CMD_HOLD;
    ctl.data   = '0;
    err_next   = err;
    count_next = count;
    div_start  = 1'b0;
    finish     = 1'b0;
    res        = '0;
    unique case (ch)
      rpn_pkg::CH_PLUS:  res = lhs + rhs;
      rpn_pkg::CH_MINUS: res = lhs - rhs;
      rpn_pkg::CH_STAR:  res = lhs * rhs;
      default:           res = quot;
    endcase
    if (state == S_EXEC) begin
      finish = 1'b1;
      if (!is_digit && !is_op && !is_space) begin
        err_next = rpn_pkg::ST_BADCHAR;
      end else if (err == rpn_pkg::ST_OK) begin
        if (is_digit) begin
          if (count == W'(D)) begin
            err_next = rpn_pkg::ST_OVERFLOW;
          end else begin
            ctl.cmd    = rpn_pkg::CMD_PUSH;
            ctl.data   = {28'd0, ch[3:0]};
            count_next = count + 1'b1;
          end
        end else if (is_op) begin
          if (count < W'(2)) begin
            err_next = rpn_pkg::ST_FEW;
          end else if (ch == rpn_pkg::CH_SLASH) begin
            if (rhs == '0) begin
              err_next = rpn_pkg::ST_DIVZERO;
            end else begin
              div_start = 1'b1;
              finish    = 1'b0;
            end
          end else begin
            ctl.cmd    = rpn_pkg::CMD_POP;
            ctl.data   = res;
            count_next = count - 1'b1;
          end
        end
      end
    end else if (state == S_DIV && div_done) begin
      finish     = 1'b1;
      ctl.cmd    = rpn_pkg::CMD_POP;
      ctl.data   = res;
      count_next = count - 1'b1;
    end
  end

  assign in_ch.ready = state == S_IDLE && !out_ch.valid;

  // Sequence: accept, execute, optionally divide, then emit on last
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= rpn_pkg::ST_OK;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          ch    <= in_ch.char_code;
          last  <= in_ch.end_of_expr;
          state <= S_EXEC;
        end
        S_EXEC: state <= div_start ? S_DIV : S_IDLE;
        S_DIV:  if (div_done) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (finish && last) begin
        out_ch.valid <= 1'b1;
        if (err_next == rpn_pkg::ST_OK && count_next != W'(1)) begin
          out_ch.status <= rpn_pkg::ST_NOTONE;
          out_ch.value  <= '0;
        end else begin
          out_ch.status <= err_next;
          out_ch.value  <= (err_next == rpn_pkg::ST_OK) ?
                           ((ctl.cmd == rpn_pkg::CMD_HOLD) ? words[0] : ctl.data) : '0;
        end
        count <= '0;
        err   <= rpn_pkg::ST_OK;
      end else begin
        if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
        count <= count_next;
        err   <= err_next;
      end
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= W'(D))
    else $error("stack count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("accept while busy");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.status <= rpn_pkg::ST_OVERFLOW)
    else $error("bad status code");
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != rpn_pkg::ST_OK |-> out_ch.value == '0)
    else $error("nonzero value with error");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives reverse Polish expressions into the evaluator one character per
// transfer and checks each value/status result against a local predictor.
// ---------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpn_in_if  in_ch (clk);
  rpn_out_if out_ch (clk);

  rpn_stack_evaluator u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  char_item_t   pending_chars[$];
  eval_result_t expected_results[$];

  // Predictor state
  logic [31:0] pred_stack[rpn_pkg::STACK_DEPTH];
  int          pred_count;
  logic [2:0]  pred_err;

  int  errors      = 0;
  int  n_chars     = 0;
  int  n_results   = 0;
  int  status_seen[6];
  bit  quiet_phase = 1'b0;
  bit  hold_send   = 1'b0;
  bit  in_taken    = 1'b0;
  int  send_gap    = 0;
  int  recv_gap    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Evaluate one accepted character; queue a result on the end mark
  task automatic evaluate_char(char_item_t it);
    logic [31:0] rhs, lhs, res;
    bit          digit, op, space;
    eval_result_t r;
    digit = it.ch >= rpn_pkg::CH_ZERO && it.ch <= rpn_pkg::CH_NINE;
    op    = it.ch inside {rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS,
                          rpn_pkg::CH_STAR, rpn_pkg::CH_SLASH};
    space = it.ch == rpn_pkg::CH_SPACE ||
            (it.ch >= rpn_pkg::CH_TAB && it.ch <= rpn_pkg::CH_CR);
    if (!digit && !op && !space) begin
      pred_err = rpn_pkg::ST_BADCHAR;
    end else if (pred_err == rpn_pkg::ST_OK) begin
      if (digit) begin
        if (pred_count >= rpn_pkg::STACK_DEPTH) pred_err = rpn_pkg::ST_OVERFLOW;
        else begin
          pred_stack[pred_count] = 32'(it.ch - rpn_pkg::CH_ZERO);
          pred_count++;
        end
      end else if (op) begin
        if (pred_count < 2) pred_err = rpn_pkg::ST_FEW;
        else begin
          rhs = pred_stack[pred_count-1];
          lhs = pred_stack[pred_count-2];
          res = 32'd0;
          case (it.ch)
            rpn_pkg::CH_PLUS:  res = lhs + rhs;
            rpn_pkg::CH_MINUS: res = lhs - rhs;
            rpn_pkg::CH_STAR:  res = lhs * rhs;
            default: begin
              if (rhs == 0) pred_err = rpn_pkg::ST_DIVZERO;
              else res = quot_trunc(lhs, rhs);
            end
          endcase
          if (pred_err == rpn_pkg::ST_OK) begin
            pred_count--;
            pred_stack[pred_count-1] = res;
          end
        end
      end
    end
    if (it.last) begin
      if (pred_err == rpn_pkg::ST_OK && pred_count != 1) pred_err = rpn_pkg::ST_NOTONE;
      r.value  = (pred_err == rpn_pkg::ST_OK) ? pred_stack[0] : 32'd0;
      r.status = pred_err;
      expected_results.push_back(r);
      pred_count = 0;
      pred_err   = rpn_pkg::ST_OK;
    end
  endtask

  function automatic void add_expr(string s);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch   = s[i];
      it.last = (i == s.len() - 1);
      pending_chars.push_back(it);
    end
  endfunction

  function automatic logic [7:0] rand_digit();
    return rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0: return rpn_pkg::CH_PLUS;
      1: return rpn_pkg::CH_MINUS;
      2: return rpn_pkg::CH_STAR;
      default: return rpn_pkg::CH_SLASH;
    endcase
  endfunction

  // Well-formed expression with random content, maybe with spaces
  function automatic void add_valid_expr(int depth);
    string s;
    int    held;
    s    = "";
    held = 0;
    while (depth > 0 || held > 1) begin
      if (depth > 0 && (held < 2 || $urandom_range(0, 1))) begin
        s = {s, string'(rand_digit())};
        held++;
        depth--;
      end else begin
        s = {s, string'(rand_op())};
        held--;
      end
      if ($urandom_range(0, 5) == 0) s = {s, " "};
    end
    add_expr(s);
  endfunction

  // Driver: change inputs at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid       <= 1'b0;
      in_ch.char_code   <= 8'd0;
      in_ch.end_of_expr <= 1'b0;
    end else begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (!quiet_phase && (!in_ch.valid || in_taken)
                   && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(1, 16);
        in_ch.valid <= 1'b0;
      end else if (pending_chars.size() > 0 && !hold_send) begin
        in_ch.valid       <= 1'b1;
        in_ch.char_code   <= pending_chars[0].ch;
        in_ch.end_of_expr <= pending_chars[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
      in_taken = 1'b0;
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: sample at the rising edge, predict and check
  always @(posedge clk) begin
    eval_result_t exp_r;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        char_item_t it;
        it.ch   = in_ch.char_code;
        it.last = in_ch.end_of_expr;
        n_chars++;
        void'(pending_chars.pop_front());
        in_taken = 1'b1;
        evaluate_char(it);
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (out_ch.status < 6) status_seen[out_ch.status]++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%0d status=%0d",
                   $time, out_ch.value, out_ch.status);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.value !== exp_r.value) begin
            errors++;
            $display("%0t: value mismatch expected=%0d actual=%0d",
                     $time, exp_r.value, out_ch.value);
          end
          if (out_ch.status !== exp_r.status) begin
            errors++;
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, exp_r.status, out_ch.status);
          end
        end
      end
    end
  end

  initial begin
    out_ch.ready      = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_code   = 8'd0;
    in_ch.end_of_expr = 1'b0;
    pred_count = 0;
    pred_err   = rpn_pkg::ST_OK;
  end

  // Stimulus
  initial begin
    string s;
    int    rnd_chars;
    char_item_t raw;
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: operators, extremes, every status
    add_expr("34+");
    add_expr("93-");
    add_expr("99*");
    add_expr("92/");
    add_expr(" 0 9-7/");                    // negative division truncates
    add_expr("0");
    add_expr("9");
    add_expr("5 0/");                       // divide by zero
    add_expr("1+");                         // too few operands
    add_expr("12");                         // two left
    add_expr(" ");                          // empty expression
    add_expr("12a+");                       // bad char
    add_expr("+x");                         // bad char overrides earlier error
    add_expr("999999999999999999");         // overflow
    add_expr("99*9*9*9*9*9*9*9*9*9*");      // multiply wraps
    s = "";
    for (int i = 0; i < 11; i++) s = {s, "9"};
    for (int i = 0; i < 10; i++) s = {s, "*"};
    add_expr({"01-", s, "*"});
    // minimum word divided by -1: build -2^31 as 0-2^31
    add_expr({"02", "2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*2*-",
              "01-/"});
    add_expr("\t1\r");
    // Single raw codes at the ends of the byte range
    raw.ch   = 8'hFF;
    raw.last = 1'b1;
    pending_chars.push_back(raw);
    raw.ch   = 8'h00;
    pending_chars.push_back(raw);

    // Pause until the pipeline has drained
    wait (pending_chars.size() == 0);
    hold_send = 1'b1;
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk);
    hold_send = 1'b0;

    // Random: mostly well-formed, some noise
    rnd_chars = 0;
    while (rnd_chars < 340) begin
      int before_n;
      before_n = pending_chars.size();
      case ($urandom_range(0, 9))
        0: begin
          s = "";
          for (int i = $urandom_range(1, 6); i > 0; i--)
            s = {s, string'(8'($urandom_range(0, 255)))};
          add_expr(s);
        end
        1: begin
          s = "";
          for (int i = $urandom_range(1, 8); i > 0; i--)
            s = {s, $urandom_range(0, 1) ? string'(rand_digit())
                                         : string'(rand_op())};
          add_expr(s);
        end
        2: add_valid_expr($urandom_range(15, 18));
        default: add_valid_expr($urandom_range(1, 8));
      endcase
      rnd_chars += pending_chars.size() - before_n;
      if (rnd_chars > 280) quiet_phase = 1'b1;
      wait (pending_chars.size() < 20);
    end
    quiet_phase = 1'b1;

    wait (pending_chars.size() == 0 && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    $display("Checked %0d characters and %0d results.", n_chars, n_results);
    $display("Status counts ok/bad/few/div0/notone/ovf: %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4], status_seen[5]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
sv/rpn_pkg.sv
sv/rpn_if.sv
sv/rpn_cell.sv
sv/rpn_div.sv
sv/rpn_stack_evaluator.sv
sim/testbench.sv
